FILE: sv/zph_pkg.sv
package zph_pkg;

  localparam int MAX_BINS   = 256;
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int NUM_BINS_W = 9;
  localparam int COORD_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [NUM_BINS_W-1:0]    NUM_BINS_RESET = NUM_BINS_W'(64);
  localparam logic signed [COORD_W-1:0] Z_LOW_RESET   = COORD_W'(0);
  localparam logic signed [COORD_W-1:0] Z_HIGH_RESET  = COORD_W'(655360);

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OUT_RANGE = 2'd1,
    STAT_BAD_RANGE = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_BINS = 2'd0,
    REG_Z_LOW    = 2'd1,
    REG_Z_HIGH   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [COORD_W-1:0]  coord_z;
    logic [IDX_W-1:0]           read_index;
  } item_t;

  typedef struct packed {
    stat_t                status;
    logic [IDX_W-1:0]     bin_index;
    logic [COUNT_W-1:0]   bin_count;
    logic [COUNT_W-1:0]   frame_count;
  } result_t;

endpackage

FILE: sv/z_position_histogram.sv
// A sample item passes the check, range, multiply, divide, lookup, update and emit
// states, and the block takes no new item until it has emitted the last result.
// The eight-step restoring bin divider produces one quotient bit a cycle. In-range
// reads skip range to divide; frame, clear, bad reads and rejected samples skip to emit.
// Reset is synchronous; it zeroes every bin count and the frame count at once through
// per-bin valid bits, with no sweep, and loads the configuration register defaults.
module z_position_histogram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  zph_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output zph_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  zph_pkg::cfg_reg_t             cfg_index,
  input  logic [zph_pkg::COORD_W-1:0]   cfg_data
);
  import zph_pkg::*;

  localparam int CNT_W = (BIN_W > 1) ? $clog2(BIN_W) : 1;
  localparam int PROD_W = COORD_W + NUM_BINS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RANGE,
    S_MUL,
    S_DIV,
    S_LOOK,
    S_UPDATE,
    S_EMIT
  } state_t;

  state_t                      state;
  item_t                       cur;
  logic [NUM_BINS_W-1:0]       num_bins;
  logic signed [COORD_W-1:0]   z_low;
  logic signed [COORD_W-1:0]   z_high;
  logic [NUM_BINS_W-1:0]       nb;
  logic [COORD_W:0]            diff;
  logic [COORD_W:0]            span;
  logic [COORD_W-1:0]          rem;
  logic [BIN_W-1:0]            qbits;
  logic [CNT_W-1:0]            cnt;
  logic [BIN_W-1:0]            addr;
  logic [MAX_BINS-1:0]         vld;
  logic [COUNT_W-1:0]          frames;
  stat_t                       res_status;
  logic [IDX_W-1:0]            res_index;
  logic [COUNT_W-1:0]          res_count;
  logic [COUNT_W-1:0]          mem [MAX_BINS];
  logic [COUNT_W-1:0]          rd_data;
  logic [PROD_W-1:0]           prod;
  logic [COORD_W:0]            trial;
  logic                        div_bit;
  logic [COORD_W-1:0]          rem_next;
  logic [BIN_W-1:0]            q_final;
  logic [COUNT_W-1:0]          count_cur;
  logic [COUNT_W-1:0]          count_next;
  logic                        mem_we;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  assign nb = (num_bins > NUM_BINS_W'(MAX_BINS)) ? NUM_BINS_W'(MAX_BINS) : num_bins;

  always_comb begin
    prod     = PROD_W'(diff[COORD_W-1:0]) * PROD_W'(nb);
    trial    = {rem, qbits[BIN_W-1]};
    div_bit  = (trial >= {1'b0, span[COORD_W-1:0]});
    rem_next = div_bit ? COORD_W'(trial - {1'b0, span[COORD_W-1:0]})
                       : trial[COORD_W-1:0];
    q_final  = {qbits[BIN_W-2:0], div_bit};
    count_cur  = vld[addr] ? rd_data : '0;
    count_next = (count_cur == '1) ? count_cur : count_cur + COUNT_W'(1);
    mem_we     = (state == S_UPDATE) && (cur.cmd == CMD_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= count_next;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vld          <= '0;
      frames       <= '0;
      result_valid <= 1'b0;
      num_bins     <= NUM_BINS_RESET;
      z_low        <= Z_LOW_RESET;
      z_high       <= Z_HIGH_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_NUM_BINS: num_bins <= cfg_data[NUM_BINS_W-1:0];
          REG_Z_LOW:    z_low    <= cfg_data;
          REG_Z_HIGH:   z_high   <= cfg_data;
          default:      ;
        endcase
      end

      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_status <= STAT_OK;
          res_index  <= '0;
          res_count  <= '0;
          unique case (cur.cmd)
            CMD_SAMPLE: begin
              diff  <= {cur.coord_z[COORD_W-1], cur.coord_z} - {z_low[COORD_W-1], z_low};
              span  <= {z_high[COORD_W-1], z_high} - {z_low[COORD_W-1], z_low};
              state <= S_RANGE;
            end
            CMD_FRAME: begin
              if (frames != '1) begin
                frames <= frames + COUNT_W'(1);
              end
              state <= S_EMIT;
            end
            CMD_READ: begin
              res_index <= cur.read_index;
              if ({1'b0, cur.read_index} >= nb) begin
                res_status <= STAT_BAD_INDEX;
                state      <= S_EMIT;
              end else begin
                addr  <= cur.read_index[BIN_W-1:0];
                state <= S_LOOK;
              end
            end
            CMD_CLEAR: begin
              vld    <= '0;
              frames <= '0;
              state  <= S_EMIT;
            end
            default: state <= S_EMIT;
          endcase
        end
        S_RANGE: begin
          if (nb == '0 || span[COORD_W] || span == '0) begin
            res_status <= STAT_BAD_RANGE;
            state      <= S_EMIT;
          end else if (diff[COORD_W] || diff >= span) begin
            res_status <= STAT_OUT_RANGE;
            state      <= S_EMIT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // The quotient stays below nb, so the high part already sits below the span.
          rem   <= prod[BIN_W +: COORD_W];
          qbits <= prod[BIN_W-1:0];
          cnt   <= CNT_W'(BIN_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= rem_next;
          qbits <= q_final;
          if (cnt == '0) begin
            if ({1'b0, q_final} < nb) begin
              addr      <= q_final;
              res_index <= IDX_W'(q_final);
              state     <= S_LOOK;
            end else begin
              res_status <= STAT_OUT_RANGE;
              state      <= S_EMIT;
            end
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_LOOK: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (cur.cmd == CMD_SAMPLE) begin
            vld[addr] <= 1'b1;
            res_count <= count_next;
          end else begin
            res_count <= count_cur;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid       <= 1'b1;
            result.status      <= res_status;
            result.bin_index   <= res_index;
            result.bin_count   <= res_count;
            result.frame_count <= frames;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
